// ===== hw/rtl/modexp_pkg.sv =====
package modexp_pkg;

  localparam int WordW = 31;
  localparam int ExpW  = 63;
  localparam int CntW  = $clog2(WordW);

  // request to the modular multiplier; operand a must not exceed m
  typedef struct packed {
    logic             go;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
    logic [WordW-1:0] m;
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] res;
  } mm_rsp_t;

endpackage

// ===== hw/rtl/modexp_modmul.sv =====
// Interleaved modular multiplier: one bit of b per cycle, MSB first.
// r = 2r mod m, then r = (r + a) mod m when the bit is set.
module modexp_modmul (
  input  logic                clk,
  input  logic                rst_n,
  input  modexp_pkg::mm_req_t req,
  output modexp_pkg::mm_rsp_t rsp
);

  typedef enum logic {
    MM_IDLE,
    MM_RUN
  } mm_state_t;

  localparam logic [modexp_pkg::CntW-1:0] LastCnt =
    modexp_pkg::CntW'(modexp_pkg::WordW - 1);

  mm_state_t                      state_r;
  logic [modexp_pkg::WordW-1:0]   a_r;
  logic [modexp_pkg::WordW-1:0]   b_r;
  logic [modexp_pkg::WordW-1:0]   m_r;
  logic [modexp_pkg::WordW-1:0]   r_r;
  logic [modexp_pkg::CntW-1:0]    cnt_r;
  logic                           done_r;

  logic [modexp_pkg::WordW:0]     dbl;
  logic [modexp_pkg::WordW:0]     dbl_red;
  logic [modexp_pkg::WordW:0]     sum;
  logic [modexp_pkg::WordW:0]     sum_red;
  logic [modexp_pkg::WordW:0]     m_ext;
  logic [modexp_pkg::WordW-1:0]   r_nxt;

  // r < m, so both the doubled and the added value stay below 2m
  always_comb begin
    m_ext   = {1'b0, m_r};
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
    sum     = dbl_red + (b_r[modexp_pkg::WordW-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= m_ext) ? sum - m_ext : sum;
    r_nxt   = sum_red[modexp_pkg::WordW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        MM_IDLE: begin
          if (req.go) begin
            a_r     <= req.a;
            b_r     <= req.b;
            m_r     <= req.m;
            r_r     <= '0;
            cnt_r   <= '0;
            state_r <= MM_RUN;
          end
        end
        MM_RUN: begin
          r_r   <= r_nxt;
          b_r   <= {b_r[modexp_pkg::WordW-2:0], 1'b0};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == LastCnt) begin
            done_r  <= 1'b1;
            state_r <= MM_IDLE;
          end
        end
        default: state_r <= MM_IDLE;
      endcase
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = r_r;

endmodule

// ===== hw/rtl/modular_exponentiation.sv =====
// Channel   | Ports                                        | Transfer
// ----------+----------------------------------------------+---------------------------
// input     | in_base_value, in_exponent_value,            | start high, busy low
//           | in_modulus_value                             |
// result    | out_power_result                             | out_valid high, one cycle
//
// Zero exponent or zero modulus: result in the cycle after the transfer, busy stays low.
// Otherwise: one modular multiply reduces the base, then per exponent bit up to the
// top set bit one decision state (ST_STEP) and the modular multiplies, one multiply
// for a clear bit and two for a set bit below the top one.
// All multiplies go through the one shared bit-serial modular multiplier.
// busy is high from the transfer until the result cycle; the receiver cannot stall.
// rst_n is synchronous; a result is never lost, out_valid pulses once per item.
module modular_exponentiation (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [modexp_pkg::WordW-1:0]   in_base_value,
  input  logic [modexp_pkg::ExpW-1:0]    in_exponent_value,
  input  logic [modexp_pkg::WordW-1:0]   in_modulus_value,
  output logic                           out_valid,
  output logic [modexp_pkg::WordW-1:0]   out_power_result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE,
    ST_STEP,
    ST_MUL,
    ST_SQR
  } state_t;

  localparam logic [modexp_pkg::WordW-1:0] One = modexp_pkg::WordW'(1);

  state_t                         state_r;
  logic [modexp_pkg::ExpW-1:0]    e_r;
  logic [modexp_pkg::WordW-1:0]   m_r;
  logic [modexp_pkg::WordW-1:0]   acc_r;
  logic [modexp_pkg::WordW-1:0]   pw_r;
  logic                           mm_go_r;
  logic [modexp_pkg::WordW-1:0]   mm_a_r;
  logic [modexp_pkg::WordW-1:0]   mm_b_r;
  logic                           out_valid_r;
  logic [modexp_pkg::WordW-1:0]   out_res_r;
  logic                           accept;

  modexp_pkg::mm_req_t mm_req;
  modexp_pkg::mm_rsp_t mm_rsp;

  assign accept = start && (state_r == ST_IDLE);

  assign mm_req.go = mm_go_r;
  assign mm_req.a  = mm_a_r;
  assign mm_req.b  = mm_b_r;
  assign mm_req.m  = m_r;

  modexp_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mm_go_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mm_go_r     <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            e_r   <= in_exponent_value;
            m_r   <= in_modulus_value;
            acc_r <= One;
            if (in_exponent_value == '0) begin
              out_valid_r <= 1'b1;
              out_res_r   <= One;
            end else if (in_modulus_value == '0) begin
              out_valid_r <= 1'b1;
              out_res_r   <= '0;
            end else begin
              // base * 1 mod m brings the base below the modulus
              mm_a_r  <= One;
              mm_b_r  <= in_base_value;
              mm_go_r <= 1'b1;
              state_r <= ST_BASE;
            end
          end
        end
        ST_BASE: begin
          if (mm_rsp.done) begin
            pw_r    <= mm_rsp.res;
            state_r <= ST_STEP;
          end
        end
        ST_STEP: begin
          mm_go_r <= 1'b1;
          if (e_r[0]) begin
            mm_a_r  <= acc_r;
            mm_b_r  <= pw_r;
            state_r <= ST_MUL;
          end else begin
            // bit clear, so higher bits remain: square only
            mm_a_r  <= pw_r;
            mm_b_r  <= pw_r;
            state_r <= ST_SQR;
          end
        end
        ST_MUL: begin
          if (mm_rsp.done) begin
            acc_r <= mm_rsp.res;
            if (e_r[modexp_pkg::ExpW-1:1] == '0) begin
              out_valid_r <= 1'b1;
              out_res_r   <= mm_rsp.res;
              state_r     <= ST_IDLE;
            end else begin
              mm_a_r  <= pw_r;
              mm_b_r  <= pw_r;
              mm_go_r <= 1'b1;
              state_r <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          if (mm_rsp.done) begin
            pw_r    <= mm_rsp.res;
            e_r     <= {1'b0, e_r[modexp_pkg::ExpW-1:1]};
            state_r <= ST_STEP;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_power_result = out_res_r;

endmodule

// ===== hw/rtl/modexp_chk.sv =====
module modexp_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [modexp_pkg::WordW-1:0]   in_base_value,
  input logic [modexp_pkg::ExpW-1:0]    in_exponent_value,
  input logic [modexp_pkg::WordW-1:0]   in_modulus_value,
  input logic                           out_valid,
  input logic [modexp_pkg::WordW-1:0]   out_power_result
);

  logic accept;
  assign accept = start && !busy;

  // zero exponent answers one on the next cycle
  a_zero_exp: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_exponent_value == '0)
    |=> out_valid && (out_power_result == modexp_pkg::WordW'(1)) && !busy)
    else $error("zero exponent did not give one");

  // zero modulus with nonzero exponent answers zero on the next cycle
  a_zero_mod: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_exponent_value != '0) && (in_modulus_value == '0)
    |=> out_valid && (out_power_result == '0) && !busy)
    else $error("zero modulus did not give zero");

  // a real exponentiation keeps the block busy and holds the result back
  a_long_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_exponent_value != '0) && (in_modulus_value != '0)
    |=> busy && !out_valid)
    else $error("exponentiation did not start");

  // a result transfer always ends the item
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result while busy");

  // busy only drops together with a result transfer
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy fell without a result");

endmodule

bind modular_exponentiation modexp_chk u_modexp_chk (.*);
